// ----- rtl/bdrb_pkg.sv -----
package bdrb_pkg;

  // Bus and payload widths
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int OFFS_W     = 21;
  localparam int BANK_W     = 7;
  localparam int RAM_BANK_W = 2;
  localparam int ROM_LO_W   = 5;
  localparam int ROM_OFFS_W = 14;
  localparam int EXT_OFFS_W = 13;

  // Number of ROM bank bits decoded (1 to 7)
  localparam int ROM_BANK_BITS = 7;
  localparam logic [BANK_W-1:0] BANK_MASK = BANK_W'((1 << ROM_BANK_BITS) - 1);

  // Memory depths
  localparam int CART_DEPTH = 2097152;
  localparam int EXT_DEPTH  = 32768;
  localparam int VRAM_DEPTH = 8192;
  localparam int WRAM_DEPTH = 8192;
  localparam int OBJ_DEPTH  = 160;
  localparam int IO_DEPTH   = 128;
  localparam int HRAM_DEPTH = 128;
  localparam int OBJ_AW     = $clog2(OBJ_DEPTH);
  localparam int IO_AW      = $clog2(IO_DEPTH);
  localparam int HRAM_AW    = $clog2(HRAM_DEPTH);
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int WRAM_AW    = $clog2(WRAM_DEPTH);

  // Clearing sweep spans the largest cleared memory
  localparam int CLR_W = $clog2(EXT_DEPTH);

  // Display registers
  localparam int DISP_NUM   = 12;
  localparam int DISP_IDX_W = 4;
  localparam int DISP_LY    = 4;
  localparam int DISP_DMA   = 6;

  // Queues
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int OB_DEPTH   = 2;
  localparam int OB_PTR_W   = $clog2(OB_DEPTH);

  localparam logic [DATA_W-1:0] BYTE_FF   = 8'hFF;
  localparam logic [DATA_W-1:0] BYTE_ZERO = 8'h00;

  typedef enum logic [1:0] {
    REQ_READ,
    REQ_WRITE,
    REQ_LOAD,
    REQ_NONE
  } req_t;

  typedef enum logic [3:0] {
    RGN_ROM0,
    RGN_ROMX,
    RGN_VRAM,
    RGN_EXT,
    RGN_WRAM,
    RGN_OBJ,
    RGN_DISP,
    RGN_IO,
    RGN_HRAM,
    RGN_NONE
  } region_t;

  // Banking register selected by address bits 14:13 of a ROM-area write
  typedef enum logic [1:0] {
    BSEL_RAM_EN,
    BSEL_ROM_LO,
    BSEL_UPPER,
    BSEL_MODE
  } bank_sel_t;

  typedef struct packed {
    req_t                kind;
    region_t             region;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic [OFFS_W-1:0]   offset;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic dma_busy;
  } back_status_t;

  // Map a bus address onto its region
  function automatic region_t decode_region(input logic [ADDR_W-1:0] a);
    region_t r;
    if (a[15:14] == 2'b00) begin
      r = RGN_ROM0;
    end else if (a[15:14] == 2'b01) begin
      r = RGN_ROMX;
    end else if (a[15:13] == 3'b100) begin
      r = RGN_VRAM;
    end else if (a[15:13] == 3'b101) begin
      r = RGN_EXT;
    end else if (a[15:13] == 3'b110) begin
      r = RGN_WRAM;
    end else if (a inside {[16'hFE00:16'hFE9F]}) begin
      r = RGN_OBJ;
    end else if (a inside {[16'hFF40:16'hFF4B]}) begin
      r = RGN_DISP;
    end else if (a inside {[16'hFF00:16'hFF7F]}) begin
      r = RGN_IO;
    end else if (a inside {[16'hFF80:16'hFFFE]}) begin
      r = RGN_HRAM;
    end else begin
      r = RGN_NONE;
    end
    return r;
  endfunction

  // Reset values of the display registers
  function automatic logic [DATA_W-1:0] disp_reset(input logic [DISP_IDX_W-1:0] idx);
    logic [DATA_W-1:0] v;
    case (idx)
      4'd0:    v = 8'h91;
      4'd1:    v = 8'h85;
      4'd7:    v = 8'hFC;
      4'd8:    v = 8'hFF;
      4'd9:    v = 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/bdrb_ram.sv -----
module bdrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

endmodule

// ----- rtl/bdrb_cmd_queue.sv -----
module bdrb_cmd_queue import bdrb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t cmd_out
);

  cmd_t                  entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_PTR_W:0]   count_r;
  logic [CMDQ_PTR_W-1:0] wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   count_nxt;

  assign full    = (count_r == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign valid   = (count_r != '0);
  assign cmd_out = entry_r[rd_ptr_r];

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + CMDQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + CMDQ_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (CMDQ_PTR_W + 1)'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - (CMDQ_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the queued transactions
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/bdrb_front.sv -----
module bdrb_front import bdrb_pkg::*; (
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_req_type,
  input  logic [ADDR_W-1:0]   in_bus_address,
  input  logic [DATA_W-1:0]   in_write_byte,
  input  logic [OFFS_W-1:0]   in_image_offset,
  input  logic                q_full,
  input  back_status_t        status,
  output logic                q_push,
  output cmd_t                q_cmd
);

  // Refuse transactions while the queue is full or memories are being cleared
  assign in_full = q_full | status.clearing;
  assign q_push  = in_push & ~in_full;

  // Classify the transaction by request kind and address region
  always_comb begin
    q_cmd.kind   = req_t'(in_req_type);
    q_cmd.region = decode_region(in_bus_address);
    q_cmd.addr   = in_bus_address;
    q_cmd.data   = in_write_byte;
    q_cmd.offset = in_image_offset;
  end

endmodule

// ----- rtl/bdrb_back.sv -----
module bdrb_back import bdrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_pop,
  output back_status_t          status,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [DATA_W-1:0]     out_read_byte,
  output logic [BANK_W-1:0]     out_current_rom_bank,
  output logic [RAM_BANK_W-1:0] out_current_ram_bank
);

  typedef enum logic [2:0] {
    SRC_CART,
    SRC_EXT,
    SRC_VRAM,
    SRC_WRAM,
    SRC_OBJ,
    SRC_IO,
    SRC_HRAM,
    SRC_FLOP
  } src_t;

  typedef struct packed {
    logic [DATA_W-1:0]     rd_byte;
    logic [BANK_W-1:0]     rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
  } result_t;

  // Banking controller and display registers
  logic                  ram_enable_r, ram_enable_nxt;
  logic [BANK_W-1:0]     rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  mode_r, mode_nxt;
  logic [DATA_W-1:0]     disp_r   [DISP_NUM];
  logic [DATA_W-1:0]     disp_nxt [DISP_NUM];

  // Clearing sweep and DMA sequencer
  logic                  clearing_r;
  logic [CLR_W-1:0]      clr_cnt_r;
  logic                  dma_active_r, dma_active_nxt;
  logic [DATA_W-1:0]     dma_base_r, dma_base_nxt;
  logic [OBJ_AW-1:0]     dma_idx_r, dma_idx_nxt;

  // Read-data stage
  logic                  s2_valid_r;
  logic                  s2_dma_r;
  src_t                  s2_src_r, s2_src_nxt;
  logic [DATA_W-1:0]     s2_flop_r, s2_flop_nxt;
  logic [OBJ_AW-1:0]     s2_dma_idx_r;
  logic [BANK_W-1:0]     s2_rom_r;
  logic [RAM_BANK_W-1:0] s2_ram_r;

  // Result buffer
  result_t               ob_mem_r [OB_DEPTH];
  logic [OB_PTR_W-1:0]   ob_head_r, ob_tail_r;
  logic [OB_PTR_W:0]     ob_cnt_r, ob_cnt_nxt;
  logic [OB_PTR_W:0]     ob_occ;
  logic                  ob_pop;
  logic                  credit_ok;
  logic                  issue;

  // Read request
  logic [ADDR_W-1:0]     rd_addr;
  region_t               rd_region;
  src_t                  rd_src;
  logic [DATA_W-1:0]     rd_flop;
  logic [DATA_W-1:0]     rd_byte;

  // Command-side write strobes
  logic wr_cart, wr_ext, wr_vram, wr_wram, wr_obj, wr_io, wr_hram;
  logic [DISP_IDX_W-1:0] disp_idx;
  logic [ROM_LO_W-1:0]   rom_lo;

  // Memory ports
  logic                  ext_we, vram_we, wram_we, obj_we, io_we, hram_we;
  logic [OFFS_W-1:0]     cart_raddr;
  logic [CLR_W-1:0]      ext_waddr, ext_raddr;
  logic [VRAM_AW-1:0]    vram_waddr;
  logic [WRAM_AW-1:0]    wram_waddr;
  logic [OBJ_AW-1:0]     obj_waddr;
  logic [IO_AW-1:0]      io_waddr;
  logic [HRAM_AW-1:0]    hram_waddr;
  logic [DATA_W-1:0]     ext_wdata, vram_wdata, wram_wdata, obj_wdata, io_wdata, hram_wdata;
  logic [DATA_W-1:0]     cart_q, ext_q, vram_q, wram_q, obj_q, io_q, hram_q;

  // Issue a command only when nothing else owns the memories and the result has room
  assign ob_pop    = out_pop & ~out_empty;
  assign ob_occ    = ob_cnt_r + (OB_PTR_W + 1)'(s2_valid_r);
  assign credit_ok = (ob_occ < (OB_PTR_W + 1)'(OB_DEPTH)) ||
                     ((ob_occ == (OB_PTR_W + 1)'(OB_DEPTH)) && ob_pop);
  assign issue     = cmd_valid & ~clearing_r & ~dma_active_r & ~s2_dma_r & credit_ok;
  assign cmd_pop   = issue;

  assign status.clearing = clearing_r;
  assign status.dma_busy = dma_active_r | s2_dma_r;

  // Select the read address: the DMA source while copying, else the command
  assign rd_addr   = dma_active_r ? {dma_base_r, dma_idx_r} : cmd.addr;
  assign rd_region = dma_active_r ? decode_region(rd_addr) : cmd.region;

  // Steer the read to its memory or to a register value
  always_comb begin
    rd_src  = SRC_FLOP;
    rd_flop = BYTE_FF;
    case (rd_region)
      RGN_ROM0, RGN_ROMX: rd_src = SRC_CART;
      RGN_VRAM:           rd_src = SRC_VRAM;
      RGN_EXT:            rd_src = ram_enable_r ? SRC_EXT : SRC_FLOP;
      RGN_WRAM:           rd_src = SRC_WRAM;
      RGN_OBJ:            rd_src = SRC_OBJ;
      RGN_DISP:           rd_flop = disp_r[rd_addr[DISP_IDX_W-1:0]];
      RGN_IO:             rd_src = SRC_IO;
      RGN_HRAM:           rd_src = SRC_HRAM;
      default:            rd_flop = BYTE_FF;
    endcase
  end

  assign cart_raddr = (rd_region == RGN_ROMX) ?
                      {rom_bank_r & BANK_MASK, rd_addr[ROM_OFFS_W-1:0]} :
                      {BANK_W'(0), rd_addr[ROM_OFFS_W-1:0]};
  assign ext_raddr  = {ram_bank_r, rd_addr[EXT_OFFS_W-1:0]};

  assign disp_idx = cmd.addr[DISP_IDX_W-1:0];
  assign rom_lo   = (cmd.data[ROM_LO_W-1:0] == '0) ? ROM_LO_W'(1) : cmd.data[ROM_LO_W-1:0];

  // Carry out the command and advance the DMA copy
  always_comb begin
    ram_enable_nxt = ram_enable_r;
    rom_bank_nxt   = rom_bank_r;
    ram_bank_nxt   = ram_bank_r;
    mode_nxt       = mode_r;
    disp_nxt       = disp_r;
    dma_active_nxt = dma_active_r;
    dma_base_nxt   = dma_base_r;
    dma_idx_nxt    = dma_idx_r;
    s2_src_nxt     = rd_src;
    s2_flop_nxt    = rd_flop;
    wr_cart        = 1'b0;
    wr_ext         = 1'b0;
    wr_vram        = 1'b0;
    wr_wram        = 1'b0;
    wr_obj         = 1'b0;
    wr_io          = 1'b0;
    wr_hram        = 1'b0;

    if (dma_active_r) begin
      dma_idx_nxt = dma_idx_r + OBJ_AW'(1);
      if (dma_idx_r == OBJ_AW'(OBJ_DEPTH - 1)) begin
        dma_active_nxt = 1'b0;
      end
    end

    if (issue) begin
      case (cmd.kind)
        REQ_READ: begin
          s2_src_nxt = rd_src;
        end
        REQ_WRITE: begin
          s2_src_nxt  = SRC_FLOP;
          s2_flop_nxt = BYTE_ZERO;
          case (cmd.region)
            RGN_ROM0, RGN_ROMX: begin
              case (bank_sel_t'(cmd.addr[14:13]))
                BSEL_RAM_EN: ram_enable_nxt = (cmd.data[3:0] == 4'hA);
                BSEL_ROM_LO: rom_bank_nxt = {rom_bank_r[BANK_W-1:ROM_LO_W], rom_lo};
                BSEL_UPPER: begin
                  if (mode_r) begin
                    ram_bank_nxt = cmd.data[RAM_BANK_W-1:0];
                  end else begin
                    rom_bank_nxt = {cmd.data[RAM_BANK_W-1:0], rom_bank_r[ROM_LO_W-1:0]};
                  end
                end
                BSEL_MODE:   mode_nxt = cmd.data[0];
                default:     mode_nxt = mode_r;
              endcase
            end
            RGN_VRAM: wr_vram = 1'b1;
            RGN_EXT:  wr_ext  = ram_enable_r;
            RGN_WRAM: wr_wram = 1'b1;
            RGN_OBJ:  wr_obj  = 1'b1;
            RGN_DISP: begin
              if (disp_idx == DISP_IDX_W'(DISP_LY)) begin
                disp_nxt[DISP_LY] = BYTE_ZERO;
              end else begin
                disp_nxt[disp_idx] = cmd.data;
                if (disp_idx == DISP_IDX_W'(DISP_DMA)) begin
                  dma_active_nxt = 1'b1;
                  dma_base_nxt   = cmd.data;
                  dma_idx_nxt    = '0;
                end
              end
            end
            RGN_IO:   wr_io   = 1'b1;
            RGN_HRAM: wr_hram = 1'b1;
            default:  wr_io   = 1'b0;
          endcase
        end
        REQ_LOAD: begin
          wr_cart     = 1'b1;
          s2_src_nxt  = SRC_FLOP;
          s2_flop_nxt = BYTE_ZERO;
        end
        default: begin
          s2_src_nxt  = SRC_FLOP;
          s2_flop_nxt = BYTE_ZERO;
        end
      endcase
    end
  end

  // Drive write ports: clearing sweep first, then DMA landing, then the command
  always_comb begin
    ext_we     = clearing_r | wr_ext;
    ext_waddr  = clearing_r ? clr_cnt_r : {ram_bank_r, cmd.addr[EXT_OFFS_W-1:0]};
    ext_wdata  = clearing_r ? BYTE_ZERO : cmd.data;
    vram_we    = clearing_r | wr_vram;
    vram_waddr = clearing_r ? clr_cnt_r[VRAM_AW-1:0] : cmd.addr[VRAM_AW-1:0];
    vram_wdata = clearing_r ? BYTE_ZERO : cmd.data;
    wram_we    = clearing_r | wr_wram;
    wram_waddr = clearing_r ? clr_cnt_r[WRAM_AW-1:0] : cmd.addr[WRAM_AW-1:0];
    wram_wdata = clearing_r ? BYTE_ZERO : cmd.data;
    io_we      = clearing_r ? (clr_cnt_r < CLR_W'(IO_DEPTH)) : wr_io;
    io_waddr   = clearing_r ? clr_cnt_r[IO_AW-1:0] : cmd.addr[IO_AW-1:0];
    io_wdata   = clearing_r ? BYTE_ZERO : cmd.data;
    hram_we    = clearing_r ? (clr_cnt_r < CLR_W'(HRAM_DEPTH)) : wr_hram;
    hram_waddr = clearing_r ? clr_cnt_r[HRAM_AW-1:0] : cmd.addr[HRAM_AW-1:0];
    hram_wdata = clearing_r ? BYTE_ZERO : cmd.data;
    if (clearing_r) begin
      obj_we    = (clr_cnt_r < CLR_W'(OBJ_DEPTH));
      obj_waddr = clr_cnt_r[OBJ_AW-1:0];
      obj_wdata = BYTE_ZERO;
    end else if (s2_dma_r) begin
      obj_we    = 1'b1;
      obj_waddr = s2_dma_idx_r;
      obj_wdata = rd_byte;
    end else begin
      obj_we    = wr_obj;
      obj_waddr = cmd.addr[OBJ_AW-1:0];
      obj_wdata = cmd.data;
    end
  end

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(CART_DEPTH)) u_cart (
    .clk(clk), .we(wr_cart), .waddr(cmd.offset), .wdata(cmd.data),
    .raddr(cart_raddr), .rd_data_r(cart_q)
  );

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(EXT_DEPTH)) u_ext (
    .clk(clk), .we(ext_we), .waddr(ext_waddr), .wdata(ext_wdata),
    .raddr(ext_raddr), .rd_data_r(ext_q)
  );

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_DEPTH)) u_vram (
    .clk(clk), .we(vram_we), .waddr(vram_waddr), .wdata(vram_wdata),
    .raddr(rd_addr[VRAM_AW-1:0]), .rd_data_r(vram_q)
  );

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(WRAM_DEPTH)) u_wram (
    .clk(clk), .we(wram_we), .waddr(wram_waddr), .wdata(wram_wdata),
    .raddr(rd_addr[WRAM_AW-1:0]), .rd_data_r(wram_q)
  );

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(OBJ_DEPTH)) u_obj (
    .clk(clk), .we(obj_we), .waddr(obj_waddr), .wdata(obj_wdata),
    .raddr(rd_addr[OBJ_AW-1:0]), .rd_data_r(obj_q)
  );

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(IO_DEPTH)) u_io (
    .clk(clk), .we(io_we), .waddr(io_waddr), .wdata(io_wdata),
    .raddr(rd_addr[IO_AW-1:0]), .rd_data_r(io_q)
  );

  bdrb_ram #(.WIDTH(DATA_W), .DEPTH(HRAM_DEPTH)) u_hram (
    .clk(clk), .we(hram_we), .waddr(hram_waddr), .wdata(hram_wdata),
    .raddr(rd_addr[HRAM_AW-1:0]), .rd_data_r(hram_q)
  );

  // Pick the byte returned by the read stage
  always_comb begin
    case (s2_src_r)
      SRC_CART: rd_byte = cart_q;
      SRC_EXT:  rd_byte = ext_q;
      SRC_VRAM: rd_byte = vram_q;
      SRC_WRAM: rd_byte = wram_q;
      SRC_OBJ:  rd_byte = obj_q;
      SRC_IO:   rd_byte = io_q;
      SRC_HRAM: rd_byte = hram_q;
      default:  rd_byte = s2_flop_r;
    endcase
  end

  // Result buffer occupancy
  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (s2_valid_r && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + (OB_PTR_W + 1)'(1);
    end else if (!s2_valid_r && ob_pop) begin
      ob_cnt_nxt = ob_cnt_r - (OB_PTR_W + 1)'(1);
    end
  end

  assign out_empty            = (ob_cnt_r == '0);
  assign out_read_byte        = ob_mem_r[ob_head_r].rd_byte;
  assign out_current_rom_bank = ob_mem_r[ob_head_r].rom_bank;
  assign out_current_ram_bank = ob_mem_r[ob_head_r].ram_bank;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      rom_bank_r   <= BANK_W'(1);
      ram_bank_r   <= '0;
      mode_r       <= 1'b0;
      for (int i = 0; i < DISP_NUM; i++) begin
        disp_r[i] <= disp_reset(DISP_IDX_W'(i));
      end
      clearing_r   <= 1'b1;
      clr_cnt_r    <= '0;
      dma_active_r <= 1'b0;
      dma_base_r   <= '0;
      dma_idx_r    <= '0;
      s2_valid_r   <= 1'b0;
      s2_dma_r     <= 1'b0;
      ob_head_r    <= '0;
      ob_tail_r    <= '0;
      ob_cnt_r     <= '0;
    end else begin
      ram_enable_r <= ram_enable_nxt;
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      mode_r       <= mode_nxt;
      disp_r       <= disp_nxt;
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == '1) begin
          clearing_r <= 1'b0;
        end
      end
      dma_active_r <= dma_active_nxt;
      dma_base_r   <= dma_base_nxt;
      dma_idx_r    <= dma_idx_nxt;
      s2_valid_r   <= issue;
      s2_dma_r     <= dma_active_r;
      if (s2_valid_r) begin
        ob_tail_r <= (ob_tail_r == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_tail_r + OB_PTR_W'(1);
      end
      if (ob_pop) begin
        ob_head_r <= (ob_head_r == OB_PTR_W'(OB_DEPTH - 1)) ? '0 : ob_head_r + OB_PTR_W'(1);
      end
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  // Read-stage and result payload
  always_ff @(posedge clk) begin
    s2_src_r     <= s2_src_nxt;
    s2_flop_r    <= s2_flop_nxt;
    s2_dma_idx_r <= dma_idx_r;
    s2_rom_r     <= rom_bank_nxt & BANK_MASK;
    s2_ram_r     <= ram_bank_nxt;
    if (s2_valid_r) begin
      ob_mem_r[ob_tail_r] <= '{rd_byte: rd_byte, rom_bank: s2_rom_r, ram_bank: s2_ram_r};
    end
  end

endmodule

// ----- rtl/bus_decoder_with_rom_ram_banking.sv -----
// Channel  Ports                                               Handshake
// -------  --------------------------------------------------  ----------------------------
// input    in_req_type in_bus_address in_write_byte            in_push, in_full
//          in_image_offset
// result   out_read_byte out_current_rom_bank                  out_pop, out_empty
//          out_current_ram_bank
//
// One transaction per cycle while in_full is low; each result passes through the command
// queue, the read stage and the result buffer. A write to the DMA register holds the back
// end while the copy runs: one object RAM read-and-land per byte through the single object
// RAM write port, until the last byte has landed. After reset a sweep zeroes every RAM but
// the cartridge image; in_full stays high until the sweep ends.
// Either side may stall freely: a two-entry command queue and a two-entry
// result buffer decouple the ports from the memory pipeline.
module bus_decoder_with_rom_ram_banking import bdrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [1:0]            in_req_type,
  input  logic [ADDR_W-1:0]     in_bus_address,
  input  logic [DATA_W-1:0]     in_write_byte,
  input  logic [OFFS_W-1:0]     in_image_offset,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [DATA_W-1:0]     out_read_byte,
  output logic [BANK_W-1:0]     out_current_rom_bank,
  output logic [RAM_BANK_W-1:0] out_current_ram_bank
);

  logic         q_push;
  cmd_t         q_cmd;
  logic         q_full;
  logic         cmd_valid;
  cmd_t         head_cmd;
  logic         cmd_pop;
  back_status_t status;

  // Classify incoming transactions
  bdrb_front u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_bus_address  (in_bus_address),
    .in_write_byte   (in_write_byte),
    .in_image_offset (in_image_offset),
    .q_full          (q_full),
    .status          (status),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // Hold classified commands between front and back
  bdrb_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (q_cmd),
    .full    (q_full),
    .pop     (cmd_pop),
    .valid   (cmd_valid),
    .cmd_out (head_cmd)
  );

  // Execute commands against banking state and memories
  bdrb_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (head_cmd),
    .cmd_pop              (cmd_pop),
    .status               (status),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_read_byte        (out_read_byte),
    .out_current_rom_bank (out_current_rom_bank),
    .out_current_ram_bank (out_current_ram_bank)
  );

`ifndef NO_ASSERTIONS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> in_full)
    else $error("transaction acceptable during clearing sweep");

  a_clear_no_results: assert property (@(posedge clk) disable iff (!rst_n)
    status.clearing |-> out_empty)
    else $error("result present during clearing sweep");

  a_dma_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    status.dma_busy |-> !cmd_pop)
    else $error("command issued while DMA copy in progress");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command queue popped while empty");
`endif

endmodule

// ----- tb/sv/bus_access_checker.sv -----
module bus_access_checker import bdrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [1:0]            in_req_type,
  input  logic [ADDR_W-1:0]     in_bus_address,
  input  logic [DATA_W-1:0]     in_write_byte,
  input  logic [OFFS_W-1:0]     in_image_offset,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic [DATA_W-1:0]     out_read_byte,
  input  logic [BANK_W-1:0]     out_current_rom_bank,
  input  logic [RAM_BANK_W-1:0] out_current_ram_bank,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // High RAM stops short of 0xFFFF, which is unmapped
  localparam int HRAM_BYTES = 127;
  localparam logic [DATA_W-1:0] DISP_INIT [DISP_NUM] = '{
    8'h91, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFC, 8'hFF, 8'hFF, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [DATA_W-1:0]     read_byte;
    logic [BANK_W-1:0]     rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
  } bus_reply_t;

  // Shadow of the bus contents and the banking controller
  logic [DATA_W-1:0]     image_bytes [int];
  logic [DATA_W-1:0]     ext_bytes   [EXT_DEPTH];
  logic [DATA_W-1:0]     vram_bytes  [VRAM_DEPTH];
  logic [DATA_W-1:0]     wram_bytes  [WRAM_DEPTH];
  logic [DATA_W-1:0]     oam_bytes   [OBJ_DEPTH];
  logic [DATA_W-1:0]     io_regs     [IO_DEPTH];
  logic [DATA_W-1:0]     hram_bytes  [HRAM_BYTES];
  logic [DATA_W-1:0]     disp_regs   [DISP_NUM];
  logic                  ram_on;
  logic [BANK_W-1:0]     rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic                  bank_mode;

  bus_reply_t replies [$];
  bus_reply_t oldest;

  function automatic void reset_bus_state();
    image_bytes.delete();
    for (int i = 0; i < EXT_DEPTH; i++) ext_bytes[i] = '0;
    for (int i = 0; i < VRAM_DEPTH; i++) vram_bytes[i] = '0;
    for (int i = 0; i < WRAM_DEPTH; i++) wram_bytes[i] = '0;
    for (int i = 0; i < OBJ_DEPTH; i++) oam_bytes[i] = '0;
    for (int i = 0; i < IO_DEPTH; i++) io_regs[i] = '0;
    for (int i = 0; i < HRAM_BYTES; i++) hram_bytes[i] = '0;
    for (int i = 0; i < DISP_NUM; i++) disp_regs[i] = DISP_INIT[i];
    ram_on    = 1'b0;
    rom_bank  = BANK_W'(1);
    ram_bank  = '0;
    bank_mode = 1'b0;
  endfunction

  function automatic logic [BANK_W-1:0] mapped_bank();
    return rom_bank & BANK_MASK;
  endfunction

  function automatic logic [DATA_W-1:0] image_byte(input logic [OFFS_W-1:0] o);
    if (image_bytes.exists(int'(o))) return image_bytes[int'(o)];
    return BYTE_ZERO;
  endfunction

  // Decode one bus read against the current shadow
  function automatic logic [DATA_W-1:0] decoded_read(input logic [ADDR_W-1:0] a);
    if (a < 16'h4000) return image_byte(OFFS_W'(a));
    if (a < 16'h8000) return image_byte({mapped_bank(), a[ROM_OFFS_W-1:0]});
    if (a < 16'hA000) return vram_bytes[a[12:0]];
    if (a < 16'hC000) return ram_on ? ext_bytes[{ram_bank, a[12:0]}] : BYTE_FF;
    if (a < 16'hE000) return wram_bytes[a[12:0]];
    if (a >= 16'hFE00 && a <= 16'hFE9F) return oam_bytes[a - 16'hFE00];
    if (a >= 16'hFF40 && a <= 16'hFF4B) return disp_regs[a - 16'hFF40];
    if (a >= 16'hFF00 && a <= 16'hFF7F) return io_regs[a[6:0]];
    if (a >= 16'hFF80 && a <= 16'hFFFE) return hram_bytes[a - 16'hFF80];
    return BYTE_FF;
  endfunction

  // Apply one bus write, banking writes and the object RAM copy included
  function automatic void decoded_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    int idx;
    if (a < 16'h8000) begin
      case (bank_sel_t'(a[14:13]))
        BSEL_RAM_EN: ram_on = (d[3:0] == 4'hA);
        BSEL_ROM_LO: rom_bank[ROM_LO_W-1:0] = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
        BSEL_UPPER: begin
          if (bank_mode) ram_bank = d[1:0];
          else rom_bank[6:5] = d[1:0];
        end
        default: bank_mode = d[0];
      endcase
    end else if (a < 16'hA000) begin
      vram_bytes[a[12:0]] = d;
    end else if (a < 16'hC000) begin
      if (ram_on) ext_bytes[{ram_bank, a[12:0]}] = d;
    end else if (a < 16'hE000) begin
      wram_bytes[a[12:0]] = d;
    end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
      oam_bytes[a - 16'hFE00] = d;
    end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
      idx = a - 16'hFF40;
      if (idx == DISP_LY) begin
        disp_regs[DISP_LY] = BYTE_ZERO;
      end else begin
        disp_regs[idx] = d;
        // Copy in order, each source read seeing the bytes already landed
        if (idx == DISP_DMA)
          for (int i = 0; i < OBJ_DEPTH; i++)
            oam_bytes[i] = decoded_read({d, 8'h00} + ADDR_W'(i));
      end
    end else if (a >= 16'hFF00 && a <= 16'hFF7F) begin
      io_regs[a[6:0]] = d;
    end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
      hram_bytes[a - 16'hFF80] = d;
    end
  endfunction

  function automatic bus_reply_t predict_reply(input req_t kind, input logic [ADDR_W-1:0] a,
                                               input logic [DATA_W-1:0] d,
                                               input logic [OFFS_W-1:0] o);
    bus_reply_t r;
    r.read_byte = BYTE_ZERO;
    case (kind)
      REQ_READ:  r.read_byte = decoded_read(a);
      REQ_WRITE: decoded_write(a, d);
      REQ_LOAD:  image_bytes[int'(o)] = d;
      default: ;
    endcase
    r.rom_bank = mapped_bank();
    r.ram_bank = ram_bank;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Retire results first, then predict the newly accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_bus_state();
      replies.delete();
      fail_count = 0;
      checked    = 0;
      pending    = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (replies.size() == 0) begin
          report_mismatch("unexpected result read_byte", out_read_byte, 0);
        end else begin
          oldest = replies.pop_front();
          checked++;
          if (out_read_byte !== oldest.read_byte)
            report_mismatch("read_byte", out_read_byte, oldest.read_byte);
          if (out_current_rom_bank !== oldest.rom_bank)
            report_mismatch("current_rom_bank", out_current_rom_bank, oldest.rom_bank);
          if (out_current_ram_bank !== oldest.ram_bank)
            report_mismatch("current_ram_bank", out_current_ram_bank, oldest.ram_bank);
        end
      end
      if (in_push && !in_full)
        replies.push_back(predict_reply(req_t'(in_req_type), in_bus_address, in_write_byte,
                                        in_image_offset));
      pending = replies.size();
    end
  end

endmodule

// ----- tb/sv/bus_decoder_with_rom_ram_banking_test.sv -----
module bus_decoder_with_rom_ram_banking_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bdrb_pkg::*;

  localparam logic [ADDR_W-1:0] DISP_BASE = 16'hFF40;
  localparam logic [ADDR_W-1:0] LY_ADDR   = DISP_BASE + ADDR_W'(DISP_LY);
  localparam logic [ADDR_W-1:0] DMA_ADDR  = DISP_BASE + ADDR_W'(DISP_DMA);
  localparam logic [ADDR_W-1:0] OAM_BASE  = 16'hFE00;
  localparam int PHASE_ITEMS = 630;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [1:0]            in_req_type;
  logic [ADDR_W-1:0]     in_bus_address;
  logic [DATA_W-1:0]     in_write_byte;
  logic [OFFS_W-1:0]     in_image_offset;
  logic                  out_empty;
  logic                  out_pop;
  logic [DATA_W-1:0]     out_read_byte;
  logic [BANK_W-1:0]     out_current_rom_bank;
  logic [RAM_BANK_W-1:0] out_current_ram_bank;
  int                    fail_count;
  int                    pending;
  int                    checked;

  // Idle rates in percent, and the request for one long receiver hold
  int send_idle_pct = 9;
  int recv_idle_pct = 69;
  bit stall_now     = 1'b0;
  bit stall_done    = 1'b0;

  // Which image bytes exist and which bank is visible, so no unloaded byte is read
  bit                    loaded_img [int];
  logic [OFFS_W-1:0]     loaded_list [$];
  logic [BANK_W-1:0]     sh_rom_bank = BANK_W'(1);
  bit                    sh_mode = 1'b0;
  logic [ADDR_W-1:0]     recent_writes [$];

  int n_items, n_reads, n_writes, n_dma, n_loads, n_none;

  bus_decoder_with_rom_ram_banking u_top (.*);
  bus_access_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random pops, plus one long hold when asked
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_now && !stall_done) begin
        stall_done = 1'b1;
        out_pop <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [BANK_W-1:0] vis_bank();
    return sh_rom_bank & BANK_MASK;
  endfunction

  function automatic logic [OFFS_W-1:0] img_offset(input logic [ADDR_W-1:0] a);
    if (a < 16'h4000) return OFFS_W'(a);
    return {vis_bank(), a[ROM_OFFS_W-1:0]};
  endfunction

  function automatic bit page_readable(input logic [7:0] p);
    for (int i = 0; i < OBJ_DEPTH; i++)
      if (!loaded_img.exists(int'(img_offset({p, 8'h00} + ADDR_W'(i))))) return 1'b0;
    return 1'b1;
  endfunction

  // Steer a copy source away from image bytes that were never loaded
  function automatic logic [7:0] safe_dma_page(input logic [7:0] p);
    if (p < 8'h80 && !page_readable(p)) return p | 8'h80;
    return p;
  endfunction

  function automatic logic [ADDR_W-1:0] bank_addr(input bank_sel_t s, input logic [12:0] low);
    return {1'b0, s, low};
  endfunction

  function automatic logic [ADDR_W-1:0] ram_addr();
    case ($urandom_range(3))
      0:       return ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
      1:       return ADDR_W'($urandom_range(16'hFE00, 16'hFFFF));
      2:       return ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
      default: return ADDR_W'($urandom_range(16'hFF00, 16'hFFFF));
    endcase
  endfunction

  // Offer one transaction and hold it until accepted; track banking on the way
  task automatic send_req(input req_t kind, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data, input logic [OFFS_W-1:0] off);
    if (kind == REQ_LOAD && !loaded_img.exists(int'(off))) begin
      loaded_img[int'(off)] = 1'b1;
      loaded_list.push_back(off);
    end
    if (kind == REQ_WRITE && !addr[15]) begin
      case (bank_sel_t'(addr[14:13]))
        BSEL_ROM_LO: sh_rom_bank[ROM_LO_W-1:0] = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
        BSEL_UPPER:  if (!sh_mode) sh_rom_bank[6:5] = data[1:0];
        BSEL_MODE:   sh_mode = data[0];
        default: ;
      endcase
    end
    n_items++;
    case (kind)
      REQ_READ:  n_reads++;
      REQ_WRITE: begin
        n_writes++;
        if (addr == DMA_ADDR) n_dma++;
      end
      REQ_LOAD:  n_loads++;
      default:   n_none++;
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_req_type     <= kind;
    in_bus_address  <= addr;
    in_write_byte   <= data;
    in_image_offset <= off;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Hold off new requests until every result is back
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Fill a ROM page as needed, then copy it into object RAM and read one byte back
  task automatic rom_page_dma();
    logic [7:0]        p;
    logic [OFFS_W-1:0] o;
    p = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(8'h40, 8'h43));
    if ($urandom_range(7) == 0) p = 8'($urandom_range(8'h7F));
    for (int i = 0; i < OBJ_DEPTH; i++) begin
      o = img_offset({p, 8'h00} + ADDR_W'(i));
      if (!loaded_img.exists(int'(o))) send_req(REQ_LOAD, ADDR_W'($urandom), 8'($urandom), o);
    end
    send_req(REQ_WRITE, DMA_ADDR, p, OFFS_W'($urandom));
    send_req(REQ_READ, OAM_BASE + ADDR_W'($urandom_range(OBJ_DEPTH - 1)), 8'($urandom),
             OFFS_W'($urandom));
  endtask

  task automatic random_access();
    int                pick;
    bit                found;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [OFFS_W-1:0] o;
    pick  = $urandom_range(99);
    d     = 8'($urandom);
    a     = ADDR_W'($urandom);
    o     = OFFS_W'($urandom);
    found = 1'b0;
    if (pick < 15) begin
      // Image load, mostly where a later read can see it
      case ($urandom_range(4))
        0, 1:    o = {vis_bank(), 14'($urandom)};
        2:       o = {7'd0, 14'($urandom)};
        default: o = OFFS_W'($urandom_range(21'h1FFFFF));
      endcase
      send_req(REQ_LOAD, a, d, o);
    end else if (pick < 30) begin
      // ROM read of a loaded byte in bank 0 or the visible bank
      for (int t = 0; t < 6 && !found; t++) begin
        o = loaded_list[$urandom_range(loaded_list.size() - 1)];
        if (o < 21'h4000) begin
          a     = o[15:0];
          found = 1'b1;
        end else if (o[20:14] == vis_bank()) begin
          a     = {2'b01, o[13:0]};
          found = 1'b1;
        end
      end
      if (!found) begin
        o = {vis_bank(), 14'($urandom)};
        a = {2'b01, o[13:0]};
        send_req(REQ_LOAD, ADDR_W'($urandom), d, o);
      end
      send_req(REQ_READ, a, 8'($urandom), OFFS_W'($urandom));
    end else if (pick < 40) begin
      // Banking controller write
      a = ADDR_W'($urandom_range(16'h7FFF));
      if ($urandom_range(1)) d[3:0] = 4'hA;
      send_req(REQ_WRITE, a, d, o);
    end else if (pick < 65) begin
      a = ram_addr();
      if (a == DMA_ADDR) d = safe_dma_page(d);
      send_req(REQ_WRITE, a, d, o);
      recent_writes.push_back(a);
      if (recent_writes.size() > 16) void'(recent_writes.pop_front());
    end else if (pick < 88) begin
      if ($urandom_range(1) && recent_writes.size() > 0)
        a = recent_writes[$urandom_range(recent_writes.size() - 1)];
      else
        a = ram_addr();
      send_req(REQ_READ, a, d, o);
    end else if (pick < 93) begin
      if ($urandom_range(1)) begin
        rom_page_dma();
      end else begin
        send_req(REQ_WRITE, DMA_ADDR, safe_dma_page(d), o);
        send_req(REQ_READ, OAM_BASE + ADDR_W'($urandom_range(OBJ_DEPTH - 1)), d, o);
      end
    end else if (pick < 96) begin
      send_req(REQ_NONE, a, d, o);
    end else begin
      // Display registers, LY and the copy trigger among them
      a = DISP_BASE + ADDR_W'($urandom_range(DISP_NUM - 1));
      if (a == DMA_ADDR) d = safe_dma_page(d);
      send_req($urandom_range(1) ? REQ_WRITE : REQ_READ, a, d, o);
    end
  endtask

  initial begin
    int goal;
    int send_pct [3] = '{9, 69, 0};
    int recv_pct [3] = '{69, 9, 0};
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_req_type     = REQ_READ;
    in_bus_address  = '0;
    in_write_byte   = '0;
    in_image_offset = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: image extremes, bank switching, RAM enable, unmapped, LY, copy
    send_req(REQ_LOAD,  16'h0000, 8'hA5, 21'h000000);
    send_req(REQ_LOAD,  16'hFFFF, 8'h5A, 21'h1FFFFF);
    send_req(REQ_READ,  16'h0000, 8'h00, 21'h000000);
    send_req(REQ_WRITE, bank_addr(BSEL_ROM_LO, 13'h0), 8'hFF, 21'h0);
    send_req(REQ_WRITE, bank_addr(BSEL_UPPER, 13'h0), 8'h03, 21'h0);
    send_req(REQ_READ,  16'h7FFF, 8'h00, 21'h0);
    send_req(REQ_WRITE, bank_addr(BSEL_ROM_LO, 13'h0), 8'h00, 21'h0);
    send_req(REQ_READ,  16'hA000, 8'h00, 21'h0);
    send_req(REQ_WRITE, 16'hA000, 8'h12, 21'h0);
    send_req(REQ_WRITE, bank_addr(BSEL_RAM_EN, 13'h0), 8'h0A, 21'h0);
    send_req(REQ_WRITE, bank_addr(BSEL_MODE, 13'h0), 8'h01, 21'h0);
    send_req(REQ_WRITE, bank_addr(BSEL_UPPER, 13'h0), 8'h02, 21'h0);
    send_req(REQ_WRITE, 16'hBFFF, 8'h77, 21'h0);
    send_req(REQ_READ,  16'hBFFF, 8'h00, 21'h0);
    send_req(REQ_READ,  16'hE000, 8'h00, 21'h0);
    send_req(REQ_READ,  16'hFFFF, 8'h00, 21'h0);
    send_req(REQ_READ,  16'hFEA0, 8'h00, 21'h0);
    send_req(REQ_WRITE, LY_ADDR, 8'h55, 21'h0);
    send_req(REQ_READ,  LY_ADDR, 8'h00, 21'h0);
    send_req(REQ_WRITE, 16'hC000, 8'h3C, 21'h0);
    send_req(REQ_WRITE, DMA_ADDR, 8'hC0, 21'h0);
    send_req(REQ_READ,  OAM_BASE, 8'h00, 21'h0);
    send_req(REQ_NONE,  16'hFF80, 8'hFF, 21'h1FFFFF);
    send_req(REQ_READ,  DISP_BASE, 8'h00, 21'h0);
    send_req(REQ_WRITE, bank_addr(BSEL_RAM_EN, 13'h1FFF), 8'h00, 21'h0);
    drain();

    // Random phases: sender-light, receiver-light, then flat out with one long hold
    goal = n_items;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      if (ph == 2) stall_now = 1'b1;
      goal += PHASE_ITEMS;
      while (n_items < goal) random_access();
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d reads, %0d writes (%0d object RAM copies), %0d image loads, %0d no-ops",
             n_reads, n_writes, n_dma, n_loads, n_none);
    $display("%0d results compared under three idle profiles and one %0d-cycle receiver hold",
             checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
